/* rtl/core/stokeslet_velocity_sum_assert.svh */
// assertion macros shared by the stokeslet velocity sum rtl
// no dependencies; included by files that carry concurrent checks
`ifndef STOKESLET_VELOCITY_SUM_ASSERT_SVH
`define STOKESLET_VELOCITY_SUM_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SVS_ASSERT_HOLD(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svs check failed");
// next-cycle implication
`define SVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svs check failed");
`else
`define SVS_ASSERT_HOLD(label, clk, rst, ante, cons)
`define SVS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/svs_pkg.sv */
// types and constants of the stokeslet velocity sum block
// no dependencies
package svs_pkg;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SINGULAR = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_SAT      = 2'd3;

   // saturation limits of the velocity words
   localparam logic [31:0] VEL_MAX = 32'h7fff_ffff;
   localparam logic [31:0] VEL_MIN = 32'h8000_0000;

   // divide / square root unit
   localparam int DSQ_NUM_W   = 72;
   localparam int DSQ_DEN_W   = 34;
   localparam int DSQ_QUO_W   = 38;
   localparam int DSQ_REM_W   = 34;
   localparam int DSQ_SH_W    = 62;
   localparam int DIV_STEPS   = 38;
   localparam int SQRT_STEPS  = 31;
   localparam int DSQ_CNT_W   = 6;

   typedef enum logic {
      DSQ_DIV,
      DSQ_SQRT
   } dsq_mode_type;

   typedef struct packed {
      logic         start;
      dsq_mode_type mode;
   } dsq_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dsq_stat_type;

endpackage

/* rtl/core/svs_req_if.sv */
// request channel: load a force or query a point
// depends on nothing
interface svs_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] x_coord;
   logic signed [15:0] y_coord;
   logic signed [15:0] force_x;
   logic signed [15:0] force_y;

   modport source (output valid, kind, x_coord, y_coord, force_x, force_y, input ready);
   modport sink (input valid, kind, x_coord, y_coord, force_x, force_y, output ready);
endinterface

/* rtl/core/svs_rsp_if.sv */
// response channel: velocity and status word
// depends on nothing
interface svs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic [1:0]         status;

   modport source (output valid, vel_x, vel_y, status, input ready);
   modport sink (input valid, vel_x, vel_y, status, output ready);
endinterface

/* rtl/core/stokeslet_velocity_sum.sv */
// top level: force table, sequencer, shared multiplier and divide/sqrt unit
// depends on svs_pkg, svs_req_if, svs_rsp_if, svs_ram, svs_mul, svs_dsq
//
// channel  direction  word
// req      in         kind, x_coord, y_coord, force_x, force_y
// rsp      out        vel_x, vel_y, status
// csr      in         coefficient write (csr_wr_en, csr_wr_data)
//
// a query walks the stored forces in turn, skipping a force on the query point without
// a root or division; the divide/square root unit resolves one bit per cycle while
// busy: one 31-step root and four 38-step divisions per force.
// reset is synchronous and clears the force count; table contents stay.
// req.ready is high only while idle; idle is entered no earlier than the edge that puts a
// result on rsp, and a held result on rsp stalls the next one.
`include "stokeslet_velocity_sum_assert.svh"
module stokeslet_velocity_sum #(
   parameter int MAX_FORCES = 16,
   parameter int FRAC_BITS  = 24
) (
   input  logic        clock,
   input  logic        reset,
   svs_req_if.sink     req,
   svs_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);
   localparam int AW         = (MAX_FORCES > 1) ? $clog2(MAX_FORCES) : 1;
   localparam int CW         = $clog2(MAX_FORCES + 1);
   localparam int PROD_SHIFT = 44 - FRAC_BITS;

   typedef enum logic [4:0] {
      ST_IDLE, ST_FETCH, ST_LATCH, ST_DXX, ST_DYY, ST_DFX, ST_DFY, ST_CHK,
      ST_SQRT, ST_N1, ST_N2, ST_N3, ST_N4, ST_DIVA, ST_DIVB, ST_T1, ST_T2,
      ST_T3, ST_FIN, ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [23:0]        coef_ff;
   logic signed [15:0] x_ff, x_in, y_ff, y_in;
   logic signed [15:0] fx_ff, fx_in, fy_ff, fy_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [33:0]        r2_ff, r2_in;
   logic [32:0]        dot_ff, dot_in;
   logic [30:0]        rq_ff, rq_in;
   logic [52:0]        n_ff, n_in;
   logic               neg_ff, neg_in;
   logic [42:0]        lo_ff, lo_in;
   logic               comp_ff, comp_in;
   logic signed [63:0] sx_ff, sx_in, sy_ff, sy_in;
   logic               sing_ff, sing_in;
   logic [31:0]        res_vx_ff, res_vx_in, res_vy_ff, res_vy_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_vx_ff, rsp_vx_in, rsp_vy_ff, rsp_vy_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               req_fire;
   logic               ram_we, ram_re;
   logic [63:0]        ram_rdata;
   logic signed [34:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [59:0] mul_p;
   svs_pkg::dsq_cmd_type  dsq_cmd;
   svs_pkg::dsq_stat_type dsq_stat;
   logic [svs_pkg::DSQ_NUM_W-1:0] dsq_num;
   logic [svs_pkg::DSQ_DEN_W-1:0] dsq_den;
   logic [svs_pkg::DSQ_QUO_W-1:0] dsq_quo;

   logic signed [15:0] fc;
   logic signed [16:0] dc;
   logic [52:0]        n_mag;
   logic [62:0]        term_sum;
   logic [62:0]        term_t;
   logic signed [63:0] term_val;
   logic [CW-1:0]      idx_nxt;
   logic               last_force;
   logic               sat_x, sat_y;
   logic               out_free;
   logic               dsq_wait;
   logic               load_full;

   // handshakes
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // force table
   svs_ram #(.WIDTH(64), .DEPTH(MAX_FORCES)) u_table (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (count_ff[AW-1:0]),
      .wr_data    ({req.x_coord, req.y_coord, req.force_x, req.force_y}),
      .rd_en      (ram_re),
      .rd_addr    (idx_ff[AW-1:0]),
      .rd_data_ff (ram_rdata)
   );

   svs_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_p)
   );

   svs_dsq u_dsq (
      .clock (clock),
      .reset (reset),
      .cmd   (dsq_cmd),
      .num   (dsq_num),
      .den   (dsq_den),
      .stat  (dsq_stat),
      .quo   (dsq_quo)
   );

   // per-component operands and term scaling
   assign fc         = comp_ff ? fy_ff : fx_ff;
   assign dc         = comp_ff ? dy_ff : dx_ff;
   assign n_mag      = n_ff[52] ? (53'd0 - n_ff) : n_ff;
   assign term_sum   = 63'(lo_ff) + (63'(mul_p[42:0]) << 19);
   assign term_t     = term_sum >> PROD_SHIFT;
   assign term_val   = neg_ff ? -$signed({1'b0, term_t}) : $signed({1'b0, term_t});
   assign idx_nxt    = idx_ff + CW'(1);
   assign last_force = (idx_nxt == count_ff);
   assign sat_x      = !((&sx_ff[63:31]) || !(|sx_ff[63:31]));
   assign sat_y      = !((&sy_ff[63:31]) || !(|sy_ff[63:31]));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      r2_in         = r2_ff;
      dot_in        = dot_ff;
      rq_in         = rq_ff;
      n_in          = n_ff;
      neg_in        = neg_ff;
      lo_in         = lo_ff;
      comp_in       = comp_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sing_in       = sing_ff;
      res_vx_in     = res_vx_ff;
      res_vy_in     = res_vy_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_vx_in     = rsp_vx_ff;
      rsp_vy_in     = rsp_vy_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      dsq_cmd.start = 1'b0;
      dsq_cmd.mode  = svs_pkg::DSQ_DIV;
      dsq_num       = '0;
      dsq_den       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in = req.x_coord;
               y_in = req.y_coord;
               if (req.kind == svs_pkg::KIND_LOAD) begin
                  res_vx_in = '0;
                  res_vy_in = '0;
                  if (count_ff < CW'(MAX_FORCES)) begin
                     ram_we        = 1'b1;
                     count_in      = count_ff + CW'(1);
                     res_status_in = svs_pkg::STATUS_OK;
                  end else begin
                     res_status_in = svs_pkg::STATUS_FULL;
                  end
                  state_in = ST_DONE;
               end else begin
                  sx_in    = '0;
                  sy_in    = '0;
                  sing_in  = 1'b0;
                  idx_in   = '0;
                  state_in = (count_ff == '0) ? ST_FIN : ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            ram_re   = 1'b1;
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            dx_in    = $signed({x_ff[15], x_ff})
                     - $signed({ram_rdata[63], ram_rdata[63:48]});
            dy_in    = $signed({y_ff[15], y_ff})
                     - $signed({ram_rdata[47], ram_rdata[47:32]});
            fx_in    = ram_rdata[31:16];
            fy_in    = ram_rdata[15:0];
            state_in = ST_DXX;
         end
         // squared distance and dot product through the multiplier
         ST_DXX: begin
            mul_a    = {{18{dx_ff[16]}}, dx_ff};
            mul_b    = {{8{dx_ff[16]}}, dx_ff};
            state_in = ST_DYY;
         end
         ST_DYY: begin
            mul_a    = {{18{dy_ff[16]}}, dy_ff};
            mul_b    = {{8{dy_ff[16]}}, dy_ff};
            r2_in    = mul_p[33:0];
            state_in = ST_DFX;
         end
         ST_DFX: begin
            mul_a    = {{18{dx_ff[16]}}, dx_ff};
            mul_b    = {{9{fx_ff[15]}}, fx_ff};
            r2_in    = r2_ff + mul_p[33:0];
            state_in = ST_DFY;
         end
         ST_DFY: begin
            mul_a    = {{18{dy_ff[16]}}, dy_ff};
            mul_b    = {{9{fy_ff[15]}}, fy_ff};
            dot_in   = mul_p[32:0];
            state_in = ST_CHK;
         end
         // skip a force on the query point, else take the root of r2
         ST_CHK: begin
            dot_in = dot_ff + mul_p[32:0];
            if (r2_ff == '0) begin
               sing_in = 1'b1;
               if (last_force) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_nxt;
                  state_in = ST_FETCH;
               end
            end else begin
               dsq_cmd.start = 1'b1;
               dsq_cmd.mode  = svs_pkg::DSQ_SQRT;
               dsq_num       = {10'b0, r2_ff, 28'b0};
               comp_in       = 1'b0;
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (dsq_stat.done) begin
               rq_in    = dsq_quo[30:0];
               state_in = ST_N1;
            end
         end
         // numerator of one component
         ST_N1: begin
            mul_a    = {1'b0, r2_ff};
            mul_b    = {{9{fc[15]}}, fc};
            state_in = ST_N2;
         end
         ST_N2: begin
            mul_a    = {{2{dot_ff[32]}}, dot_ff};
            mul_b    = {{8{dc[16]}}, dc};
            n_in     = mul_p[52:0];
            state_in = ST_N3;
         end
         ST_N3: begin
            n_in     = n_ff + mul_p[52:0];
            state_in = ST_N4;
         end
         ST_N4: begin
            neg_in        = n_ff[52];
            dsq_cmd.start = 1'b1;
            dsq_num       = {n_mag[51:0], 20'b0};
            dsq_den       = r2_ff;
            state_in      = ST_DIVA;
         end
         ST_DIVA: begin
            if (dsq_stat.done) begin
               dsq_cmd.start = 1'b1;
               dsq_num       = {20'b0, dsq_quo, 14'b0};
               dsq_den       = {3'b0, rq_ff};
               state_in      = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (dsq_stat.done) begin
               state_in = ST_T1;
            end
         end
         // scale by the coefficient in two partial products
         ST_T1: begin
            mul_a    = {11'b0, coef_ff};
            mul_b    = {6'b0, dsq_quo[18:0]};
            state_in = ST_T2;
         end
         ST_T2: begin
            mul_a    = {11'b0, coef_ff};
            mul_b    = {6'b0, dsq_quo[37:19]};
            lo_in    = mul_p[42:0];
            state_in = ST_T3;
         end
         ST_T3: begin
            if (!comp_ff) begin
               sx_in    = sx_ff + term_val;
               comp_in  = 1'b1;
               state_in = ST_N1;
            end else begin
               sy_in = sy_ff + term_val;
               if (last_force) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_nxt;
                  state_in = ST_FETCH;
               end
            end
         end
         // clamp and status
         ST_FIN: begin
            res_vx_in = sat_x ? (sx_ff[63] ? svs_pkg::VEL_MIN : svs_pkg::VEL_MAX) : sx_ff[31:0];
            res_vy_in = sat_y ? (sy_ff[63] ? svs_pkg::VEL_MIN : svs_pkg::VEL_MAX) : sy_ff[31:0];
            if (sat_x || sat_y) begin
               res_status_in = svs_pkg::STATUS_SAT;
            end else if (sing_ff) begin
               res_status_in = svs_pkg::STATUS_SINGULAR;
            end else begin
               res_status_in = svs_pkg::STATUS_OK;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vx_in     = res_vx_ff;
               rsp_vy_in     = res_vy_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         coef_ff      <= 24'd9536;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            coef_ff <= csr_wr_data;
         end
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      fx_ff         <= fx_in;
      fy_ff         <= fy_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      r2_ff         <= r2_in;
      dot_ff        <= dot_in;
      rq_ff         <= rq_in;
      n_ff          <= n_in;
      neg_ff        <= neg_in;
      lo_ff         <= lo_in;
      comp_ff       <= comp_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      sing_ff       <= sing_in;
      res_vx_ff     <= res_vx_in;
      res_vy_ff     <= res_vy_in;
      res_status_ff <= res_status_in;
      rsp_vx_ff     <= rsp_vx_in;
      rsp_vy_ff     <= rsp_vy_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.vel_x  = rsp_vx_ff;
   assign rsp.vel_y  = rsp_vy_ff;
   assign rsp.status = rsp_status_ff;

   // terms for the checks
   assign dsq_wait  = (state_ff == ST_SQRT) || (state_ff == ST_DIVA) || (state_ff == ST_DIVB);
   assign load_full = req_fire && (req.kind == svs_pkg::KIND_LOAD)
                    && (count_ff == CW'(MAX_FORCES));

   // checks
   `SVS_ASSERT_HOLD(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_FORCES))
   `SVS_ASSERT_HOLD(a_fetch_in_table, clock, reset, state_ff == ST_FETCH, idx_ff < count_ff)
   `SVS_ASSERT_HOLD(a_done_when_waiting, clock, reset, dsq_stat.done, dsq_wait)
   `SVS_ASSERT_NEXT(a_full_status, clock, reset, load_full, res_status_ff == svs_pkg::STATUS_FULL)
endmodule

/* rtl/core/svs_ram.sv */
// generic single write, single read ram with registered read
// no dependencies
module svs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end
endmodule

/* rtl/core/svs_mul.sv */
// shared signed multiplier with registered product
// no dependencies
module svs_mul (
   input  logic               clock,
   input  logic signed [34:0] mul_a,
   input  logic signed [24:0] mul_b,
   output logic signed [59:0] prod_ff
);
   logic signed [59:0] prod_in;

   // one product per cycle
   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

/* rtl/core/svs_dsq.sv */
// iterative divide / square root unit, one quotient or root bit per cycle
// depends on svs_pkg and the assertion header
`include "stokeslet_velocity_sum_assert.svh"
module svs_dsq (
   input  logic                                clock,
   input  logic                                reset,
   input  svs_pkg::dsq_cmd_type                cmd,
   input  logic [svs_pkg::DSQ_NUM_W-1:0]       num,
   input  logic [svs_pkg::DSQ_DEN_W-1:0]       den,
   output svs_pkg::dsq_stat_type               stat,
   output logic [svs_pkg::DSQ_QUO_W-1:0]       quo
);
   logic [svs_pkg::DSQ_REM_W-1:0] rem_ff, rem_in;
   logic [svs_pkg::DSQ_SH_W-1:0]  sh_ff, sh_in;
   logic [svs_pkg::DSQ_QUO_W-1:0] quo_ff, quo_in;
   logic [svs_pkg::DSQ_DEN_W-1:0] den_ff, den_in;
   logic [svs_pkg::DSQ_CNT_W-1:0] cnt_ff, cnt_in;
   svs_pkg::dsq_mode_type         mode_ff, mode_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   logic [35:0] trial;
   logic [35:0] subtr;
   logic [35:0] diff;
   logic        ge;

   // shared compare-subtract step
   always_comb begin
      if (mode_ff == svs_pkg::DSQ_DIV) begin
         trial = {1'b0, rem_ff, sh_ff[svs_pkg::DSQ_SH_W-1]};
         subtr = {2'b00, den_ff};
      end else begin
         trial = {rem_ff, sh_ff[svs_pkg::DSQ_SH_W-1 -: 2]};
         subtr = {quo_ff[33:0], 2'b01};
      end
      ge   = (trial >= subtr);
      diff = trial - subtr;
   end

   // sequencing of the steps
   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         mode_in = cmd.mode;
         den_in  = den;
         quo_in  = '0;
         busy_in = 1'b1;
         if (cmd.mode == svs_pkg::DSQ_DIV) begin
            rem_in = num[svs_pkg::DSQ_NUM_W-1 -: svs_pkg::DSQ_REM_W];
            sh_in  = {num[svs_pkg::DIV_STEPS-1:0], 24'b0};
            cnt_in = svs_pkg::DSQ_CNT_W'(svs_pkg::DIV_STEPS);
         end else begin
            rem_in = '0;
            sh_in  = num[svs_pkg::DSQ_SH_W-1:0];
            cnt_in = svs_pkg::DSQ_CNT_W'(svs_pkg::SQRT_STEPS);
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[svs_pkg::DSQ_REM_W-1:0] : trial[svs_pkg::DSQ_REM_W-1:0];
         sh_in  = (mode_ff == svs_pkg::DSQ_DIV) ? (sh_ff << 1) : (sh_ff << 2);
         quo_in = {quo_ff[svs_pkg::DSQ_QUO_W-2:0], ge};
         cnt_in = cnt_ff - svs_pkg::DSQ_CNT_W'(1);
         if (cnt_ff == svs_pkg::DSQ_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      mode_ff <= mode_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = quo_ff;

   // checks
   `SVS_ASSERT_HOLD(a_no_start_busy, clock, reset, cmd.start, !busy_ff)
   `SVS_ASSERT_HOLD(a_done_idle, clock, reset, done_ff, !busy_ff)
   `SVS_ASSERT_HOLD(a_busy_count, clock, reset, busy_ff, cnt_ff != '0)
endmodule
